/* hdl/c2bruv_pkg.sv */
// ----------------------------------------------------------------------------
// c2bruv_pkg
// Shared widths, register indexes, reset values and word types for the
// bistatic Cartesian to range / direction-cosine converter.
// ----------------------------------------------------------------------------
package c2bruv_pkg;

  // field widths
  localparam int POS_W     = 20;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int RANGE_W   = 23;
  localparam int DIR_W     = 16;

  // datapath widths
  localparam int DIFF_W = POS_W + 1;          // position difference
  localparam int PROD_W = DIFF_W + COEF_W;    // coefficient times difference
  localparam int LOC_W  = PROD_W + 1;         // three products, |sum| <= 3*2^35
  localparam int ERR_W  = LOC_W + 1;          // target minus transmitter, local
  localparam int MAG_W  = ERR_W - 1;          // magnitude, |err| < 2^38
  localparam int HALF_W = MAG_W / 2;          // split for partial products
  localparam int SQ_W   = 2 * MAG_W;          // one square
  localparam int NRM_W  = SQ_W + 2;           // sum of three squares
  localparam int ROOT_W = NRM_W / 2;          // integer square root
  localparam int QUO_W  = FRAC_BITS + 1;      // cosine magnitude, <= 2^FRAC_BITS

  // configuration port
  localparam int ROW_W      = 3 * COEF_W;
  localparam int VEC_W      = 3 * POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VEC_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TX_POSITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RX_POSITION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_RANGE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_W   = 3'd6;

  // identity matrix at reset
  localparam logic [ROW_W-1:0] ROT_ROW0_RESET = 48'd16384;
  localparam logic [ROW_W-1:0] ROT_ROW1_RESET = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROT_ROW2_RESET = 48'd70368744177664;

  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
  localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] target_z;
  } in_word_t;

  typedef struct packed {
    logic [RANGE_W-1:0]      range_sum;
    logic signed [DIR_W-1:0] dir_u;
    logic signed [DIR_W-1:0] dir_v;
    logic signed [DIR_W-1:0] dir_w;
    logic                    zero_range;
  } out_word_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] rot_row;
    logic [VEC_W-1:0]      tx_position;
    logic [VEC_W-1:0]      rx_position;
    logic                  half_range;
    logic                  include_w;
  } cfg_t;

  // word handed from the front end to the back end
  typedef struct packed {
    logic [2:0][MAG_W-1:0] loc_mag;
    logic [2:0]            loc_neg;
    logic [2:0][MAG_W-1:0] err_mag;
    logic                  zero_range;
  } front_word_t;

endpackage

/* hdl/c2bruv_front.sv */
// ----------------------------------------------------------------------------
// c2bruv_front
// Front end: subtracts the receiver position, rotates target and transmitter
// into receiver axes, forms magnitudes and flags a zero local vector.
// ----------------------------------------------------------------------------
module c2bruv_front (
  input  logic                     clk,
  input  logic                     rst,
  input  c2bruv_pkg::cfg_t         cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  c2bruv_pkg::in_word_t     in_data,
  input  logic                     q_full,
  output logic                     q_push,
  output c2bruv_pkg::front_word_t  q_word
);

  localparam int POS_W  = c2bruv_pkg::POS_W;
  localparam int COEF_W = c2bruv_pkg::COEF_W;
  localparam int DIFF_W = c2bruv_pkg::DIFF_W;
  localparam int PROD_W = c2bruv_pkg::PROD_W;
  localparam int LOC_W  = c2bruv_pkg::LOC_W;
  localparam int ERR_W  = c2bruv_pkg::ERR_W;
  localparam int MAG_W  = c2bruv_pkg::MAG_W;

  logic                     adv;
  logic [3:0]               vld;
  logic signed [POS_W-1:0]  tgt    [3];
  logic signed [POS_W-1:0]  tx_c   [3];
  logic signed [POS_W-1:0]  rx_c   [3];
  logic signed [COEF_W-1:0] coef   [3][3];
  logic signed [DIFF_W-1:0] d_tgt  [3];
  logic signed [DIFF_W-1:0] d_tx   [3];
  logic signed [PROD_W-1:0] p_tgt  [3][3];
  logic signed [PROD_W-1:0] p_tx   [3][3];
  logic signed [LOC_W-1:0]  loc    [3];
  logic signed [LOC_W-1:0]  loc_tx [3];
  logic signed [ERR_W-1:0]  err    [3];
  logic [MAG_W-1:0]         loc_abs[3];
  logic [MAG_W-1:0]         err_abs[3];
  c2bruv_pkg::front_word_t  word;

  // handshake: the whole front end holds while its last word cannot leave
  always_comb begin
    adv      = !(vld[3] && q_full);
    in_stall = !adv;
    q_push   = vld[3] && adv;
    q_word   = word;
  end

  // unpack operands
  always_comb begin
    tgt[0] = in_data.target_x;
    tgt[1] = in_data.target_y;
    tgt[2] = in_data.target_z;
    for (int i = 0; i < 3; i++) begin
      tx_c[i] = $signed(cfg.tx_position[POS_W*i +: POS_W]);
      rx_c[i] = $signed(cfg.rx_position[POS_W*i +: POS_W]);
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = $signed(cfg.rot_row[i][COEF_W*j +: COEF_W]);
      end
    end
  end

  // magnitudes of the local target and the target-to-transmitter vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      err[i]     = ERR_W'(loc[i]) - ERR_W'(loc_tx[i]);
      loc_abs[i] = loc[i][LOC_W-1] ? MAG_W'(-loc[i]) : MAG_W'(loc[i]);
      err_abs[i] = err[i][ERR_W-1] ? MAG_W'(-err[i]) : MAG_W'(err[i]);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // four stages: difference, products, sums, magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_tgt[i] <= DIFF_W'(tgt[i]) - DIFF_W'(rx_c[i]);
        d_tx[i]  <= DIFF_W'(tx_c[i]) - DIFF_W'(rx_c[i]);
        for (int j = 0; j < 3; j++) begin
          p_tgt[i][j] <= PROD_W'(coef[i][j]) * PROD_W'(d_tgt[j]);
          p_tx[i][j]  <= PROD_W'(coef[i][j]) * PROD_W'(d_tx[j]);
        end
        loc[i]    <= LOC_W'(p_tgt[i][0]) + LOC_W'(p_tgt[i][1]) + LOC_W'(p_tgt[i][2]);
        loc_tx[i] <= LOC_W'(p_tx[i][0]) + LOC_W'(p_tx[i][1]) + LOC_W'(p_tx[i][2]);
        word.loc_mag[i] <= loc_abs[i];
        word.loc_neg[i] <= loc[i][LOC_W-1];
        word.err_mag[i] <= err_abs[i];
      end
      word.zero_range <= (loc[0] == '0) && (loc[1] == '0) && (loc[2] == '0);
    end
  end

endmodule

/* hdl/c2bruv_queue.sv */
// ----------------------------------------------------------------------------
// c2bruv_queue
// Short queue between front and back end so each can stall on its own.
// ----------------------------------------------------------------------------
module c2bruv_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  c2bruv_pkg::front_word_t  push_word,
  output logic                     full,
  input  logic                     pop,
  output c2bruv_pkg::front_word_t  pop_word,
  output logic                     empty
);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);

  c2bruv_pkg::front_word_t mem [QDEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [PTR_W:0]          count;

  always_comb begin
    full     = (count == (PTR_W+1)'(QDEPTH));
    empty    = (count == '0);
    pop_word = mem[rd_ptr];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

/* hdl/c2bruv_back.sv */
// ----------------------------------------------------------------------------
// c2bruv_back
// Back end: squares, two pipelined integer square roots, range sum and three
// pipelined restoring dividers for the direction cosines.
// ----------------------------------------------------------------------------
module c2bruv_back (
  input  logic                     clk,
  input  logic                     rst,
  input  c2bruv_pkg::cfg_t         cfg,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  c2bruv_pkg::front_word_t  q_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output c2bruv_pkg::out_word_t    out_data
);

  localparam int MAG_W     = c2bruv_pkg::MAG_W;
  localparam int HALF_W    = c2bruv_pkg::HALF_W;
  localparam int SQ_W      = c2bruv_pkg::SQ_W;
  localparam int NRM_W     = c2bruv_pkg::NRM_W;
  localparam int ROOT_W    = c2bruv_pkg::ROOT_W;
  localparam int QUO_W     = c2bruv_pkg::QUO_W;
  localparam int FRAC_BITS = c2bruv_pkg::FRAC_BITS;
  localparam int RANGE_W   = c2bruv_pkg::RANGE_W;
  localparam int DIR_W     = c2bruv_pkg::DIR_W;
  localparam int NSTG      = ROOT_W + FRAC_BITS + 5;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] loc_mag;
    logic [2:0]            loc_neg;
    logic                  zero_range;
  } carry_t;

  typedef struct packed {
    logic [NRM_W-1:0]  rad;
    logic [ROOT_W:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [ROOT_W-1:0]      divisor;
    logic [2:0][ROOT_W-1:0] rem;
    logic [2:0][QUO_W-1:0]  quo;
    logic [2:0]             neg;
    logic                   zero_range;
    logic [RANGE_W-1:0]     range_sum;
  } div_st_t;

  // one result bit of the square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    logic [ROOT_W+2:0] acc;
    logic [ROOT_W+2:0] trial;
    sqrt_st_t          r;
    acc   = {s.rem, s.rad[NRM_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[NRM_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = (ROOT_W+1)'(acc - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = (ROOT_W+1)'(acc);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit on each of the three lanes
  function automatic div_st_t div_step(div_st_t s);
    logic [ROOT_W:0] acc;
    div_st_t         r;
    r = s;
    for (int i = 0; i < 3; i++) begin
      acc = {s.rem[i], 1'b0};
      if (acc >= {1'b0, s.divisor}) begin
        r.rem[i] = ROOT_W'(acc - {1'b0, s.divisor});
        r.quo[i] = {s.quo[i][QUO_W-2:0], 1'b1};
      end else begin
        r.rem[i] = ROOT_W'(acc);
        r.quo[i] = {s.quo[i][QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic                  adv;
  logic [NSTG-1:0]       vld;
  logic [MAG_W-1:0]      mag_in [6];
  carry_t                c0;
  carry_t                c1;
  logic [2*HALF_W-1:0]   pp_hh [6];
  logic [2*HALF_W-1:0]   pp_hl [6];
  logic [2*HALF_W-1:0]   pp_ll [6];
  logic [SQ_W-1:0]       sq    [6];
  sqrt_st_t              nrm1  [ROOT_W+1];
  sqrt_st_t              nrm2  [ROOT_W+1];
  carry_t                cs    [ROOT_W+1];
  div_st_t               dv    [FRAC_BITS+1];
  div_st_t               dv_init;
  logic [ROOT_W:0]       r_sum;
  logic [ROOT_W:0]       r_shift;
  logic [ROOT_W-1:0]     dividend;
  logic signed [DIR_W-1:0] dir [3];

  // whole back end moves unless the output word is held
  always_comb begin
    adv       = !(vld[NSTG-1] && out_stall);
    q_pop     = adv && !q_empty;
    out_valid = vld[NSTG-1];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i]     = q_word.loc_mag[i];
      mag_in[i + 3] = q_word.err_mag[i];
    end
  end

  // first divider step and the range sum, from the finished roots
  always_comb begin
    dv_init.divisor    = nrm1[ROOT_W].root;
    dv_init.neg        = cs[ROOT_W].loc_neg;
    dv_init.zero_range = cs[ROOT_W].zero_range;
    dividend           = '0;
    for (int i = 0; i < 3; i++) begin
      dividend = ROOT_W'(cs[ROOT_W].loc_mag[i]);
      if (dividend >= nrm1[ROOT_W].root) begin
        dv_init.rem[i] = dividend - nrm1[ROOT_W].root;
        dv_init.quo[i] = QUO_W'(1);
      end else begin
        dv_init.rem[i] = dividend;
        dv_init.quo[i] = '0;
      end
    end
    r_sum   = (ROOT_W+1)'(nrm1[ROOT_W].root) + (ROOT_W+1)'(nrm2[ROOT_W].root);
    r_shift = cfg.half_range ? (r_sum >> (FRAC_BITS + 1)) : (r_sum >> FRAC_BITS);
    if (r_shift > (ROOT_W+1)'(c2bruv_pkg::RANGE_MAX)) begin
      dv_init.range_sum = c2bruv_pkg::RANGE_MAX;
    end else begin
      dv_init.range_sum = RANGE_W'(r_shift);
    end
  end

  // signed cosines from the last divider stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = dv[FRAC_BITS].neg[i] ? -DIR_W'(dv[FRAC_BITS].quo[i])
                                    :  DIR_W'(dv[FRAC_BITS].quo[i]);
      if (dv[FRAC_BITS].zero_range) begin
        dir[i] = '0;
      end
    end
    if (!cfg.include_w) begin
      dir[2] = '0;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], q_pop};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // partial products of each square
      c0.loc_mag    <= q_word.loc_mag;
      c0.loc_neg    <= q_word.loc_neg;
      c0.zero_range <= q_word.zero_range;
      for (int k = 0; k < 6; k++) begin
        pp_hh[k] <= mag_in[k][MAG_W-1:HALF_W] * mag_in[k][MAG_W-1:HALF_W];
        pp_hl[k] <= mag_in[k][MAG_W-1:HALF_W] * mag_in[k][HALF_W-1:0];
        pp_ll[k] <= mag_in[k][HALF_W-1:0] * mag_in[k][HALF_W-1:0];
      end
      // squares
      c1 <= c0;
      for (int k = 0; k < 6; k++) begin
        sq[k] <= (SQ_W'(pp_hh[k]) << (2 * HALF_W)) + (SQ_W'(pp_hl[k]) << (HALF_W + 1))
               + SQ_W'(pp_ll[k]);
      end
      // sums of squares seed the root pipelines
      nrm1[0].rad  <= NRM_W'(sq[0]) + NRM_W'(sq[1]) + NRM_W'(sq[2]);
      nrm1[0].rem  <= '0;
      nrm1[0].root <= '0;
      nrm2[0].rad  <= NRM_W'(sq[3]) + NRM_W'(sq[4]) + NRM_W'(sq[5]);
      nrm2[0].rem  <= '0;
      nrm2[0].root <= '0;
      cs[0]        <= c1;
      // square root, one bit a stage
      for (int k = 0; k < ROOT_W; k++) begin
        nrm1[k+1] <= sqrt_step(nrm1[k]);
        nrm2[k+1] <= sqrt_step(nrm2[k]);
        cs[k+1]   <= cs[k];
      end
      // division, one quotient bit a stage
      dv[0] <= dv_init;
      for (int k = 0; k < FRAC_BITS; k++) begin
        dv[k+1] <= div_step(dv[k]);
      end
      // output word
      out_data.range_sum  <= dv[FRAC_BITS].range_sum;
      out_data.dir_u      <= dir[0];
      out_data.dir_v      <= dir[1];
      out_data.dir_w      <= dir[2];
      out_data.zero_range <= dv[FRAC_BITS].zero_range;
    end
  end

endmodule

/* hdl/cartesian_to_bistatic_ruv.sv */
// ----------------------------------------------------------------------------
// cartesian_to_bistatic_ruv
// Bistatic Cartesian to range and direction-cosine converter, top level.
// ----------------------------------------------------------------------------
// Input words (target x, y, z) arrive on in_valid / in_stall / in_data and
// result words leave on out_valid / out_stall / out_data; a word moves on a
// clock edge with valid high and stall low. Every input word gives exactly
// one result word, in order.
// Throughput is one word per clock while out_stall is low. A word passes
// four front-end stages, the queue, three square stages, the two
// bit-per-stage square roots (39 stages) and the bit-per-stage cosine
// dividers (15 stages), then the output register.
// Registers are written on cfg_valid / cfg_ready / cfg_index / cfg_data;
// cfg_ready is always high. Write them only while no word is in flight.
// Reset (rst, synchronous) empties the pipeline and queue and loads the
// identity matrix, zero positions, full range and w disabled.
// When out_stall is held the back end freezes, the four-word queue fills,
// then the front end freezes and in_stall rises. No word is dropped.
// ----------------------------------------------------------------------------
module cartesian_to_bistatic_ruv (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  c2bruv_pkg::in_word_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output c2bruv_pkg::out_word_t                  out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [c2bruv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [c2bruv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ROW_W = c2bruv_pkg::ROW_W;
  localparam int VEC_W = c2bruv_pkg::VEC_W;

  c2bruv_pkg::cfg_t        cfg;
  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_empty;
  c2bruv_pkg::front_word_t q_in;
  c2bruv_pkg::front_word_t q_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_row[0]  <= c2bruv_pkg::ROT_ROW0_RESET;
      cfg.rot_row[1]  <= c2bruv_pkg::ROT_ROW1_RESET;
      cfg.rot_row[2]  <= c2bruv_pkg::ROT_ROW2_RESET;
      cfg.tx_position <= '0;
      cfg.rx_position <= '0;
      cfg.half_range  <= 1'b0;
      cfg.include_w   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        c2bruv_pkg::REG_ROT_ROW0:    cfg.rot_row[0]  <= cfg_data[ROW_W-1:0];
        c2bruv_pkg::REG_ROT_ROW1:    cfg.rot_row[1]  <= cfg_data[ROW_W-1:0];
        c2bruv_pkg::REG_ROT_ROW2:    cfg.rot_row[2]  <= cfg_data[ROW_W-1:0];
        c2bruv_pkg::REG_TX_POSITION: cfg.tx_position <= cfg_data[VEC_W-1:0];
        c2bruv_pkg::REG_RX_POSITION: cfg.rx_position <= cfg_data[VEC_W-1:0];
        c2bruv_pkg::REG_HALF_RANGE:  cfg.half_range  <= cfg_data[0];
        c2bruv_pkg::REG_INCLUDE_W:   cfg.include_w   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  c2bruv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_in)
  );

  c2bruv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_out),
    .empty     (q_empty)
  );

  c2bruv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_word    (q_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // the front end never writes a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // the back end never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // zero local range forces all cosines to zero
  a_zero_cos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.zero_range) |->
      (out_data.dir_u == '0 && out_data.dir_v == '0 && out_data.dir_w == '0))
    else $error("cosine nonzero with zero range");

  // the u and v cosines never exceed one in magnitude
  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ($signed(out_data.dir_u) <= c2bruv_pkg::DIR_ONE &&
       $signed(out_data.dir_u) >= -c2bruv_pkg::DIR_ONE &&
       $signed(out_data.dir_v) <= c2bruv_pkg::DIR_ONE &&
       $signed(out_data.dir_v) >= -c2bruv_pkg::DIR_ONE))
    else $error("cosine out of range");
`endif

endmodule

/* test/cartesian_to_bistatic_ruv_tb.sv */
// ----------------------------------------------------------------------------
// cartesian_to_bistatic_ruv_tb
// Self-checking bench for the bistatic range / direction-cosine converter.
// Target words are driven under several register settings, with random idle
// gaps on both channels. A scoreboard predicts each result word and compares
// it, field by field and in order, with the words that the block returns.
// ----------------------------------------------------------------------------
module cartesian_to_bistatic_ruv_tb;

  localparam int POS_W      = c2bruv_pkg::POS_W;
  localparam int COEF_W     = c2bruv_pkg::COEF_W;
  localparam int FRAC_BITS  = c2bruv_pkg::FRAC_BITS;
  localparam int RANGE_W    = c2bruv_pkg::RANGE_W;
  localparam int DIR_W      = c2bruv_pkg::DIR_W;
  localparam int ROW_W      = c2bruv_pkg::ROW_W;
  localparam int VEC_W      = c2bruv_pkg::VEC_W;
  localparam int CFG_IDX_W  = c2bruv_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = c2bruv_pkg::CFG_DATA_W;

  // scoreboard: register copy, expected-word queue, range/cosine predictor
  class ruv_scoreboard;
    logic [ROW_W-1:0] rot [3];
    logic [VEC_W-1:0] tx, rx;
    logic             half, incw;
    c2bruv_pkg::out_word_t expected_q [$];
    int               mismatches;

    function new();
      rot[0] = c2bruv_pkg::ROT_ROW0_RESET;
      rot[1] = c2bruv_pkg::ROT_ROW1_RESET;
      rot[2] = c2bruv_pkg::ROT_ROW2_RESET;
      tx = '0;
      rx = '0;
      half = 1'b0;
      incw = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        c2bruv_pkg::REG_ROT_ROW0:    rot[0] = val[ROW_W-1:0];
        c2bruv_pkg::REG_ROT_ROW1:    rot[1] = val[ROW_W-1:0];
        c2bruv_pkg::REG_ROT_ROW2:    rot[2] = val[ROW_W-1:0];
        c2bruv_pkg::REG_TX_POSITION: tx = val;
        c2bruv_pkg::REG_RX_POSITION: rx = val;
        c2bruv_pkg::REG_HALF_RANGE:  half = val[0];
        c2bruv_pkg::REG_INCLUDE_W:   incw = val[0];
        default: ;
      endcase
    endfunction

    // floor of the Euclidean norm of a scaled local vector
    function logic [63:0] norm_floor(longint a, longint b, longint c);
      logic [127:0] ma, mb, mc, n, cand, res;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      mc = (c < 0) ? -c : c;
      n = ma * ma + mb * mb + mc * mc;
      res = '0;
      for (int i = 55; i >= 0; i--) begin
        cand = res | (128'd1 << i);
        if (cand * cand <= n) res = cand;
      end
      return res[63:0];
    endfunction

    // component over r1, truncated toward zero
    function longint dir_cos(longint c, longint r);
      longint a, q;
      a = (c < 0) ? -c : c;
      q = (a << FRAC_BITS) / r;
      return (c < 0) ? -q : q;
    endfunction

    function c2bruv_pkg::out_word_t predict(c2bruv_pkg::in_word_t t);
      longint tgt [3], dt [3], dx [3], lt [3], lx [3];
      longint r1, r2, total;
      c2bruv_pkg::out_word_t o;
      tgt[0] = t.target_x;
      tgt[1] = t.target_y;
      tgt[2] = t.target_z;
      for (int i = 0; i < 3; i++) begin
        dt[i] = tgt[i] - longint'($signed(rx[i*POS_W +: POS_W]));
        dx[i] = longint'($signed(tx[i*POS_W +: POS_W]))
                - longint'($signed(rx[i*POS_W +: POS_W]));
      end
      for (int i = 0; i < 3; i++) begin
        lt[i] = 0;
        lx[i] = 0;
        for (int j = 0; j < 3; j++) begin
          lt[i] += longint'($signed(rot[i][j*COEF_W +: COEF_W])) * dt[j];
          lx[i] += longint'($signed(rot[i][j*COEF_W +: COEF_W])) * dx[j];
        end
      end
      r1 = norm_floor(lt[0], lt[1], lt[2]);
      r2 = norm_floor(lt[0] - lx[0], lt[1] - lx[1], lt[2] - lx[2]);
      total = (r1 + r2) >>> (FRAC_BITS + (half ? 1 : 0));
      if (total > longint'(c2bruv_pkg::RANGE_MAX)) total = c2bruv_pkg::RANGE_MAX;
      o = '0;
      o.range_sum = RANGE_W'(total);
      o.zero_range = (r1 == 0);
      if (r1 != 0) begin
        o.dir_u = DIR_W'(dir_cos(lt[0], r1));
        o.dir_v = DIR_W'(dir_cos(lt[1], r1));
        if (incw) o.dir_w = DIR_W'(dir_cos(lt[2], r1));
      end
      return o;
    endfunction

    function void note_target(c2bruv_pkg::in_word_t t);
      expected_q.push_back(predict(t));
    endfunction

    function void check_result(c2bruv_pkg::out_word_t got);
      c2bruv_pkg::out_word_t exp_w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.range_sum !== exp_w.range_sum || got.dir_u !== exp_w.dir_u ||
          got.dir_v !== exp_w.dir_v || got.dir_w !== exp_w.dir_w ||
          got.zero_range !== exp_w.zero_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", exp_w, got);
      end
    endfunction
  endclass

  logic      clk, rst;
  logic      in_valid, in_stall, out_valid, out_stall;
  c2bruv_pkg::in_word_t  in_data;
  c2bruv_pkg::out_word_t out_data;
  logic      cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ruv_scoreboard sb = new();
  int snd_idle = 0, rcv_idle = 0;
  int quiet_cycles = 0;

  cartesian_to_bistatic_ruv dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("cartesian_to_bistatic_ruv verification failed");
      $finish;
    end
  end

  // register write; cfg_valid is left high for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic load_regs(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                           logic [ROW_W-1:0] r2, logic [VEC_W-1:0] txp,
                           logic [VEC_W-1:0] rxp, logic hf, logic iw);
    write_reg(c2bruv_pkg::REG_ROT_ROW0, CFG_DATA_W'(r0));
    write_reg(c2bruv_pkg::REG_ROT_ROW1, CFG_DATA_W'(r1));
    write_reg(c2bruv_pkg::REG_ROT_ROW2, CFG_DATA_W'(r2));
    write_reg(c2bruv_pkg::REG_TX_POSITION, txp);
    write_reg(c2bruv_pkg::REG_RX_POSITION, rxp);
    write_reg(c2bruv_pkg::REG_HALF_RANGE, CFG_DATA_W'(hf));
    write_reg(c2bruv_pkg::REG_INCLUDE_W, CFG_DATA_W'(iw));
    cfg_valid <= 1'b0;
  endtask

  // send one target word, with random idle cycles ahead of it
  task automatic send_target(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z);
    c2bruv_pkg::in_word_t w;
    w.target_x = x;
    w.target_y = y;
    w.target_z = z;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_target(w);
  endtask

  // wait for every expected word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [VEC_W-1:0] rand_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ROW_W'({$urandom, $urandom});
  endfunction

  // random targets: mostly anywhere, some at or near the receiver or at the transmitter
  task automatic random_targets(int n);
    logic [POS_W-1:0] p [3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 9))
          0:       p[i] = sb.rx[i*POS_W +: POS_W];
          1:       p[i] = sb.rx[i*POS_W +: POS_W] + POS_W'($urandom_range(0, 6))
                          - POS_W'(3);
          2:       p[i] = sb.tx[i*POS_W +: POS_W];
          default: p[i] = POS_W'($urandom);
        endcase
      end
      if ($urandom_range(0, 19) == 0) p = '{sb.rx[0 +: POS_W], sb.rx[POS_W +: POS_W],
                                            sb.rx[2*POS_W +: POS_W]};
      send_target(p[0], p[1], p[2]);
    end
  endtask

  localparam logic [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under reset settings: origin, extremes, axes
    send_target('0, '0, '0);
    send_target(PMAX, PMAX, PMAX);
    send_target(PMIN, PMIN, PMIN);
    send_target(PMAX, PMIN, '0);
    send_target('0, '0, PMIN);
    send_target(POS_W'(1), '0, '0);
    send_target('0, POS_W'(-1), '0);
    drain();

    // directed words with w enabled, halved range and offset sites
    load_regs(c2bruv_pkg::ROT_ROW0_RESET, c2bruv_pkg::ROT_ROW1_RESET,
              c2bruv_pkg::ROT_ROW2_RESET,
              {POS_W'(-1000), POS_W'(300), POS_W'(5000)},
              {POS_W'(7), POS_W'(-9), POS_W'(11)}, 1'b1, 1'b1);
    send_target(POS_W'(7), POS_W'(-9), POS_W'(11));
    send_target(POS_W'(5000), POS_W'(300), POS_W'(-1000));
    send_target(POS_W'(8), POS_W'(-9), POS_W'(11));
    send_target(PMAX, PMAX, PMAX);
    send_target(PMIN, PMIN, PMIN);
    send_target('0, '0, PMAX);
    drain();

    // saturation: coefficients at -2, receiver and transmitter at opposite corners
    load_regs({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
              {3{PMIN}}, {3{PMAX}}, 1'b0, 1'b1);
    send_target(PMIN, PMIN, PMIN);
    send_target(PMAX, PMAX, PMAX);
    send_target(PMIN, PMAX, PMIN);
    drain();

    // random phases under varied settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      snd_idle = (ph < 2) ? 24 : (ph < 4) ? 82 : 0;
      rcv_idle = (ph < 2) ? 82 : (ph < 4) ? 24 : 0;
      case (ph)
        0: load_regs(c2bruv_pkg::ROT_ROW0_RESET, c2bruv_pkg::ROT_ROW1_RESET,
                     c2bruv_pkg::ROT_ROW2_RESET,
                     rand_vec(), rand_vec(), 1'b0, 1'b1);
        1: load_regs(rand_row(), rand_row(), rand_row(),
                     rand_vec(), rand_vec(), 1'b1, 1'b1);
        2: load_regs({3{16'h7FFF}}, {16'h8000, 16'h7FFF, 16'h8000}, {3{16'hFFFF}},
                     {3{PMAX}}, {3{PMIN}}, 1'b0, 1'b1);
        3: load_regs('0, '0, '0, rand_vec(), rand_vec(), 1'b1, 1'b0);
        4: load_regs(rand_row(), rand_row(), rand_row(),
                     rand_vec(), rand_vec(), 1'($urandom), 1'b1);
        default: begin
          logic [VEC_W-1:0] site;
          site = rand_vec();
          load_regs(48'd1073741824, 48'd16384, 48'd70368744177664,
                    site, site, 1'b0, 1'b0);
        end
      endcase
      random_targets(240);
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("cartesian_to_bistatic_ruv verification clean");
    else
      $display("cartesian_to_bistatic_ruv verification failed");
    $finish;
  end

endmodule
